// ----- hw/rtl/mf2u_pkg.sv -----
// ----------------------------------------------------------------------------
// mf2u_pkg
// Shared types, constants and character helpers for the multipart field to
// URL-encoding converter.
// ----------------------------------------------------------------------------
package mf2u_pkg;

	// Default depth of the job queue between front and back
	localparam int unsigned QueueDepthDef = 4;

	// Character codes
	localparam logic [7:0] ChDash  = 8'h2D;
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChPct   = 8'h25;
	localparam logic [7:0] ChEq    = 8'h3D;
	localparam logic [7:0] ChN     = 8'h6E;

	// Status codes on the final beat of a message
	localparam logic [1:0] StOk       = 2'd0;
	localparam logic [1:0] StNoName   = 2'd1;
	localparam logic [1:0] StNameOpen = 2'd2;
	localparam logic [1:0] StBody     = 2'd3;

	// Input beat
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_message;
	} src_item_t;

	// Output beat
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic [1:0] status;
		logic       last_result;
	} dst_item_t;

	// One classified byte: held dashes, then a character, then a status
	typedef struct packed {
		logic [1:0] dashes;
		logic       char_en;
		logic       enc;
		logic [7:0] chr;
		logic       stat_en;
		logic [1:0] stat;
	} job_t;

	// Characters of the "name=" key
	function automatic logic [7:0] key_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h6E;
			3'd1:    c = 8'h61;
			3'd2:    c = 8'h6D;
			3'd3:    c = 8'h65;
			3'd4:    c = 8'h3D;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Bytes copied as they are in URL-encoding
	function automatic logic is_safe(input logic [7:0] b);
		return (b == 8'h2E) || (b == 8'h2D) || (b == 8'h5F) ||
			(b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
			(b >= 8'h30 && b <= 8'h39);
	endfunction

	// Upper-case hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + {4'd0, n};
		end else begin
			c = 8'h37 + {4'd0, n};
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/mf2u_front.sv -----
// ----------------------------------------------------------------------------
// mf2u_front
// Parses the message byte by byte and turns each byte into one job that
// says which result beats it causes.
// ----------------------------------------------------------------------------
module mf2u_front
	import mf2u_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  src_item_t item,
	output logic      push,
	output job_t      job
);

	localparam logic [2:0] PhPrefix   = 3'd0;
	localparam logic [2:0] PhPass     = 3'd1;
	localparam logic [2:0] PhFindName = 3'd2;
	localparam logic [2:0] PhSkip     = 3'd3;
	localparam logic [2:0] PhName     = 3'd4;
	localparam logic [2:0] PhBlank    = 3'd5;
	localparam logic [2:0] PhBody     = 3'd6;
	localparam logic [2:0] PhDone     = 3'd7;

	logic [2:0] phase_q, phase_d, ph_mid;
	logic [1:0] dash_q, dash_d;
	logic [2:0] match_q, match_d;
	logic [7:0] b;

	assign b = item.in_byte;

	// Classify the byte and work out the next parse state
	always_comb begin
		job     = '0;
		phase_d = phase_q;
		dash_d  = dash_q;
		match_d = match_q;

		// leading dash check and pass-through
		if (phase_q == PhPrefix) begin
			if (dash_q != 2'd3) begin
				if (b == ChDash) begin
					dash_d = dash_q + 2'd1;
				end else begin
					job.dashes  = dash_q;
					job.char_en = 1'b1;
					job.chr     = b;
					phase_d     = PhPass;
				end
			end else begin
				phase_d = PhFindName;
				match_d = 3'd0;
			end
		end else if (phase_q == PhPass) begin
			job.char_en = 1'b1;
			job.chr     = b;
		end
		ph_mid = phase_d;

		// multipart parse on the phase reached so far
		unique case (ph_mid)
			PhFindName: begin
				if (match_d < 3'd5 && b == key_char(match_d)) begin
					if (match_d == 3'd4) begin
						phase_d = PhSkip;
						match_d = 3'd0;
					end else begin
						match_d = match_d + 3'd1;
					end
				end else begin
					match_d = (b == ChN) ? 3'd1 : 3'd0;
				end
			end
			PhSkip: begin
				phase_d = PhName;
			end
			PhName: begin
				job.char_en = 1'b1;
				if (b == ChQuote) begin
					job.chr = ChEq;
					phase_d = PhBlank;
					match_d = 3'd0;
				end else begin
					job.chr = b;
				end
			end
			PhBlank: begin
				// progress: 0 none, 1 CR, 2 CR LF, 3 CR LF CR, 4 LF
				if (b == ChLf) begin
					if (match_d == 3'd0) begin
						match_d = 3'd4;
					end else if (match_d == 3'd1) begin
						match_d = 3'd2;
					end else begin
						phase_d = PhBody;
						match_d = 3'd0;
					end
				end else if (b == ChCr) begin
					match_d = (match_d == 3'd2) ? 3'd3 : 3'd1;
				end else begin
					match_d = 3'd0;
				end
			end
			PhBody: begin
				// progress: 0 none, 1 LF, 2 LF dash, 3 LF dash dash
				if (b == ChDash && match_d != 3'd0) begin
					if (match_d >= 3'd3) begin
						phase_d = PhDone;
						match_d = 3'd0;
					end else begin
						match_d = match_d + 3'd1;
					end
				end else begin
					job.dashes  = (match_d >= 3'd2) ? 2'(match_d - 3'd1) : 2'd0;
					job.char_en = 1'b1;
					job.enc     = 1'b1;
					job.chr     = b;
					match_d     = (b == ChLf) ? 3'd1 : 3'd0;
				end
			end
			default: begin
			end
		endcase

		// close the message with a status beat and rearm
		if (item.end_of_message) begin
			job.stat_en = 1'b1;
			unique case (phase_d)
				PhPrefix: begin
					job.dashes = dash_d;
					job.stat   = StOk;
				end
				PhFindName:      job.stat = StNoName;
				PhSkip, PhName:  job.stat = StNameOpen;
				PhBlank, PhBody: job.stat = StBody;
				default:         job.stat = StOk;
			endcase
			phase_d = PhPrefix;
			dash_d  = 2'd0;
			match_d = 3'd0;
		end
	end

	// Push only jobs that cause at least one beat
	assign push = accept && (job.dashes != 2'd0 || job.char_en || job.stat_en);

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhPrefix;
			dash_q  <= 2'd0;
			match_q <= 3'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			dash_q  <= dash_d;
			match_q <= match_d;
		end
	end

endmodule

// ----- hw/rtl/mf2u_queue.sv -----
// ----------------------------------------------------------------------------
// mf2u_queue
// Short first-in first-out store of jobs between the parser and the
// character generator.
// ----------------------------------------------------------------------------
module mf2u_queue
	import mf2u_pkg::*;
#(
	parameter int unsigned Depth = QueueDepthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t head,
	output logic empty,
	output logic full
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(Depth);

	job_t            mem [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CntFull);
	assign head  = mem[rd_ptr_q];

	// Store the job
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/mf2u_back.sv -----
// ----------------------------------------------------------------------------
// mf2u_back
// Expands the job at the queue head into result beats, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module mf2u_back
	import mf2u_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  job_t      head,
	input  logic      empty,
	output logic      pop,
	output logic      dst_valid,
	input  logic      dst_ready,
	output dst_item_t dst_data
);

	logic [2:0] step_q;
	logic [2:0] n_beats, j;
	logic [1:0] n_char;
	logic       plain, load, last_beat;
	dst_item_t  beat;
	dst_item_t  data_q;
	logic       valid_q;

	// Count the beats of the head job
	always_comb begin
		plain   = !head.enc || is_safe(head.chr) || head.chr == ChSpace;
		n_char  = !head.char_en ? 2'd0 : (plain ? 2'd1 : 2'd3);
		n_beats = {1'b0, head.dashes} + {1'b0, n_char} + {2'd0, head.stat_en};
		j       = step_q - {1'b0, head.dashes};
	end

	// Pick the beat at the current step
	always_comb begin
		beat = '0;
		if (step_q < {1'b0, head.dashes}) begin
			beat.out_char   = ChDash;
			beat.char_valid = 1'b1;
		end else if (j < {1'b0, n_char}) begin
			beat.char_valid = 1'b1;
			if (!head.enc || is_safe(head.chr)) begin
				beat.out_char = head.chr;
			end else if (head.chr == ChSpace) begin
				beat.out_char = ChPlus;
			end else if (j == 3'd0) begin
				beat.out_char = ChPct;
			end else if (j == 3'd1) begin
				beat.out_char = hex_char(head.chr[7:4]);
			end else begin
				beat.out_char = hex_char(head.chr[3:0]);
			end
		end else begin
			beat.status      = head.stat;
			beat.last_result = 1'b1;
		end
	end

	assign load      = !empty && (!valid_q || dst_ready);
	assign last_beat = (step_q == n_beats - 3'd1);
	assign pop       = load && last_beat;

	// Step through the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 3'd0;
		end else if (load) begin
			step_q <= last_beat ? 3'd0 : step_q + 3'd1;
		end
	end

	// Hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (dst_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= beat;
		end
	end

	assign dst_valid = valid_q;
	assign dst_data  = data_q;

endmodule

// ----- hw/rtl/multipart_field_to_url_encoding.sv -----
// Path: a byte's job is queued, then each of its beats is registered at the output.
// Throughput: one result beat per cycle unless stalled; a byte causes 0 to 6
// beats (3 for a percent-encoded byte), so the back end sets the sustained rate.
// The front takes one byte per cycle while the job queue has room.
// Reset: arst_n clears the parse state, empties the queue and drops the output beat.
// ----------------------------------------------------------------------------
// multipart_field_to_url_encoding
// Converts one multipart form field to a URL-encoded "name=value" stream,
// passing other messages through, with a status beat closing each message.
// ----------------------------------------------------------------------------
module multipart_field_to_url_encoding
	import mf2u_pkg::*;
#(
	parameter int unsigned QueueDepth = QueueDepthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_ready,
	input  src_item_t src_data,
	output logic      dst_valid,
	input  logic      dst_ready,
	output dst_item_t dst_data
);

	logic accept, push, pop, empty, full;
	job_t job, head;

	assign src_ready = !full;
	assign accept    = src_valid && src_ready;

	// Parse and classify
	mf2u_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (src_data),
		.push   (push),
		.job    (job)
	);

	// Decouple parse from generation
	mf2u_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (job),
		.pop    (pop),
		.head   (head),
		.empty  (empty),
		.full   (full)
	);

	// Generate result beats
	mf2u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	// Never draw from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job popped from empty queue");

	// Every queued job yields at least one beat
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (job.dashes != 2'd0 || job.char_en || job.stat_en))
		else $error("empty job queued");

	// A status beat carries no character
	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_data.last_result) |-> (!dst_data.char_valid &&
		dst_data.out_char == 8'h00))
		else $error("status beat carries a character");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams multipart posts, broken posts and plain messages through the form
// field to URL-encoding converter. A local model of the parser predicts every
// output beat, and each beat taken at the output is checked against the
// oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import mf2u_pkg::*;

	localparam int unsigned ItemsTarget = 345;
	localparam int unsigned CycleLimit  = 400000;
	localparam int unsigned DrainCycles = 20;

	typedef enum logic [3:0] {
		ScanPrefix,
		PassThrough,
		SeekKey,
		SkipOpen,
		CopyName,
		SeekBlank,
		EncodeBody,
		SkipTail
	} parse_phase_t;

	typedef struct {
		src_item_t   beat;
		int unsigned gap;
		bit          drain;
	} post_entry_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_ready;
	src_item_t src_data = '0;
	logic      dst_valid;
	logic      dst_ready = 1'b0;
	dst_item_t dst_data;

	// Parser state of the local model
	parse_phase_t phase = ScanPrefix;
	logic [1:0]   held_dashes = 2'd0;
	logic [2:0]   scan_pos = 3'd0;
	string        key_text = "name=";
	string        hex_digits = "0123456789ABCDEF";

	dst_item_t    encoded_q[$];
	post_entry_t  post_q[$];
	logic [7:0]   msg[$];

	logic         src_taken = 1'b0;
	logic         dst_taken = 1'b0;
	int unsigned  n_posted = 0;
	int unsigned  n_taken = 0;
	int unsigned  n_beats = 0;
	int unsigned  n_errors = 0;
	int unsigned  cycle_cnt = 0;
	int unsigned  tx_wait = 0;
	int unsigned  rx_hold = 0;

	multipart_field_to_url_encoding i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data (src_data),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_data (dst_data)
	);

	// Clock and reset
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Expected beats
	task automatic emit_char(input logic [7:0] c);
		dst_item_t r;
		r.out_char = c;
		r.char_valid = 1'b1;
		r.status = StOk;
		r.last_result = 1'b0;
		encoded_q.push_back(r);
	endtask

	task automatic emit_status(input logic [1:0] s);
		dst_item_t r;
		r.out_char = 8'h00;
		r.char_valid = 1'b0;
		r.status = s;
		r.last_result = 1'b1;
		encoded_q.push_back(r);
	endtask

	task automatic emit_encoded(input logic [7:0] b);
		if (b == 8'h2E || b == ChDash || b == 8'h5F || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A) || (b >= 8'h30 && b <= 8'h39)) begin
			emit_char(b);
		end else if (b == ChSpace) begin
			emit_char(ChPlus);
		end else begin
			emit_char(ChPct);
			emit_char(hex_digits[b[7:4]]);
			emit_char(hex_digits[b[3:0]]);
		end
	endtask

	// Release dashes held back while matching the closing boundary
	task automatic flush_body_dashes();
		int k;
		if (scan_pos >= 3'd2) begin
			for (k = 1; k < scan_pos; k++) begin
				emit_char(ChDash);
			end
		end
	endtask

	// Advance the parser by one message byte and queue the beats it causes
	task automatic convert_byte(input src_item_t it);
		logic [7:0] b;
		logic [1:0] st;
		int k;
		b = it.in_byte;

		// Decide between multipart and plain pass-through
		if (phase == ScanPrefix) begin
			if (held_dashes < 2'd3) begin
				if (b == ChDash) begin
					held_dashes = held_dashes + 2'd1;
				end else begin
					for (k = 0; k < held_dashes; k++) begin
						emit_char(ChDash);
					end
					emit_char(b);
					phase = PassThrough;
				end
			end else begin
				phase = SeekKey;
				scan_pos = 3'd0;
			end
		end else if (phase == PassThrough) begin
			emit_char(b);
		end

		// Multipart parsing, on the phase just reached
		if (phase == SeekKey) begin
			if (scan_pos < 3'd5 && b == key_text[scan_pos]) begin
				scan_pos = scan_pos + 3'd1;
				if (scan_pos >= 3'd5) begin
					phase = SkipOpen;
					scan_pos = 3'd0;
				end
			end else begin
				scan_pos = (b == ChN) ? 3'd1 : 3'd0;
			end
		end else if (phase == SkipOpen) begin
			phase = CopyName;
		end else if (phase == CopyName) begin
			if (b == ChQuote) begin
				emit_char(ChEq);
				phase = SeekBlank;
				scan_pos = 3'd0;
			end else begin
				emit_char(b);
			end
		end else if (phase == SeekBlank) begin
			// progress: 0 none, 1 CR, 2 CR LF, 3 CR LF CR, 4 LF
			if (b == ChLf) begin
				if (scan_pos == 3'd0) begin
					scan_pos = 3'd4;
				end else if (scan_pos == 3'd1) begin
					scan_pos = 3'd2;
				end else begin
					phase = EncodeBody;
					scan_pos = 3'd0;
				end
			end else if (b == ChCr) begin
				scan_pos = (scan_pos == 3'd2) ? 3'd3 : 3'd1;
			end else begin
				scan_pos = 3'd0;
			end
		end else if (phase == EncodeBody) begin
			// progress: 0 none, 1 LF, 2 LF dash, 3 LF dash dash
			if (b == ChLf) begin
				flush_body_dashes();
				emit_encoded(b);
				scan_pos = 3'd1;
			end else if (b == ChDash && scan_pos >= 3'd1) begin
				if (scan_pos >= 3'd3) begin
					phase = SkipTail;
					scan_pos = 3'd0;
				end else begin
					scan_pos = scan_pos + 3'd1;
				end
			end else begin
				flush_body_dashes();
				emit_encoded(b);
				scan_pos = 3'd0;
			end
		end

		// Close the message with its status beat
		if (it.end_of_message) begin
			case (phase)
				ScanPrefix: begin
					for (k = 0; k < held_dashes; k++) begin
						emit_char(ChDash);
					end
					st = StOk;
				end
				SeekKey: st = StNoName;
				SkipOpen, CopyName: st = StNameOpen;
				SeekBlank, EncodeBody: st = StBody;
				default: st = StOk;
			endcase
			emit_status(st);
			phase = ScanPrefix;
			held_dashes = 2'd0;
			scan_pos = 3'd0;
		end
	endtask

	// Message building
	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			msg.push_back(s[i]);
		end
	endtask

	task automatic post_message(input bit drain_first, input bit calm);
		post_entry_t e;
		int i;
		for (i = 0; i < msg.size(); i++) begin
			e.beat.in_byte = msg[i];
			e.beat.end_of_message = (i == msg.size() - 1);
			e.gap = calm ? 0 : $urandom_range(0, 4);
			e.drain = drain_first && (i == 0);
			post_q.push_back(e);
			n_posted++;
		end
		msg.delete();
	endtask

	// Sender: present the next byte once the gap has passed
	always @(negedge clk) begin : drive_src
		logic      nxt_valid;
		src_item_t nxt_data;
		nxt_valid = src_valid;
		nxt_data = src_data;
		if (src_taken) begin
			nxt_valid = 1'b0;
		end
		if (arst_n && !nxt_valid && post_q.size() != 0) begin
			// hold a draining byte back until every predicted beat is out
			if (!(post_q[0].drain && encoded_q.size() != 0)) begin
				if (tx_wait < post_q[0].gap) begin
					tx_wait++;
				end else begin
					nxt_data = post_q[0].beat;
					nxt_valid = 1'b1;
					post_q.delete(0);
					tx_wait = 0;
				end
			end
		end
		src_valid <= nxt_valid;
		src_data <= nxt_data;
	end

	// Receiver: stall at random after each beat, with calm stretches
	always @(negedge clk) begin
		if (dst_taken) begin
			rx_hold = (((n_beats / 64) % 4) == 3) ? 0 : $urandom_range(0, 4);
		end
		if (rx_hold != 0) begin
			dst_ready <= 1'b0;
			rx_hold--;
		end else begin
			dst_ready <= 1'b1;
		end
	end

	// Predict on accepted bytes, check accepted beats
	always @(posedge clk) begin : check_dst
		dst_item_t want;
		src_taken <= arst_n && src_valid && src_ready;
		dst_taken <= arst_n && dst_valid && dst_ready;
		if (arst_n && src_valid && src_ready) begin
			convert_byte(src_data);
			n_taken++;
		end
		if (arst_n && dst_valid && dst_ready) begin
			n_beats++;
			if (encoded_q.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected beat: char %h valid %b status %0d last %b",
					$time, dst_data.out_char, dst_data.char_valid, dst_data.status,
					dst_data.last_result);
			end else begin
				want = encoded_q.pop_front();
				if (dst_data.char_valid !== want.char_valid ||
					dst_data.status !== want.status ||
					dst_data.last_result !== want.last_result ||
					(want.char_valid && dst_data.out_char !== want.out_char)) begin
					n_errors++;
					$display({"%0t: mismatch: expected char %h valid %b status %0d last %b,",
						" got char %h valid %b status %0d last %b"}, $time,
						want.out_char, want.char_valid, want.status, want.last_result,
						dst_data.out_char, dst_data.char_valid, dst_data.status,
						dst_data.last_result);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		int unsigned m;
		int unsigned kind;
		int unsigned cut;
		logic [7:0]  b;
		string       safe_set;
		safe_set = "._-0123456789AZaz";

		// Directed: a lone dash, two dashes, zero and all-ones bytes passed
		// through, a post ending before the key, and a minimal complete post
		add_text("-");
		post_message(1'b0, 1'b0);
		add_text("--");
		post_message(1'b0, 1'b1);
		msg.push_back(8'h00);
		msg.push_back(8'hFF);
		post_message(1'b0, 1'b0);
		add_text("---n");
		post_message(1'b0, 1'b0);
		add_text("---name=\"\"");
		msg.push_back(ChLf);
		msg.push_back(ChLf);
		msg.push_back(ChLf);
		add_text("---");
		post_message(1'b0, 1'b1);

		// Random: mostly well-formed posts with random content, some cut short,
		// the rest noise
		for (m = 0; n_posted < ItemsTarget; m++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 7) begin
				add_text("---");
				repeat ($urandom_range(0, 3)) msg.push_back(8'(8'h61 + $urandom_range(0, 25)));
				add_text("name=");
				msg.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : ChQuote);
				repeat ($urandom_range(0, 3)) begin
					do begin
						b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
							8'(8'h41 + $urandom_range(0, 25));
					end while (b == ChQuote);
					msg.push_back(b);
				end
				msg.push_back(ChQuote);
				// header noise before the blank line
				repeat ($urandom_range(0, 2)) begin
					case ($urandom_range(0, 2))
						0: b = ChCr;
						1: b = ChLf;
						default: b = 8'(8'h61 + $urandom_range(0, 25));
					endcase
					msg.push_back(b);
				end
				if ($urandom_range(0, 1) == 0) begin
					msg.push_back(ChLf);
					msg.push_back(ChLf);
				end else begin
					msg.push_back(ChCr);
					msg.push_back(ChLf);
					msg.push_back(ChCr);
					msg.push_back(ChLf);
				end
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 5))
						0: b = 8'($urandom_range(0, 255));
						1: b = ChSpace;
						2: b = ChDash;
						3: b = ChLf;
						4: b = ChCr;
						default: b = safe_set[$urandom_range(0, safe_set.len() - 1)];
					endcase
					msg.push_back(b);
				end
				msg.push_back(ChLf);
				add_text("---");
				repeat ($urandom_range(0, 2)) msg.push_back(8'($urandom_range(0, 255)));
				// cut the post short
				if (kind >= 6) begin
					cut = $urandom_range(1, msg.size());
					while (msg.size() > cut) begin
						void'(msg.pop_back());
					end
				end
			end else begin
				repeat ((kind == 9) ? 3 : $urandom_range(0, 3)) msg.push_back(ChDash);
				repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom_range(0, 255)));
			end
			post_message((m == 0) || ($urandom_range(0, 7) == 0), (m % 5) == 4);
		end

		// Wait for the last byte, the last beat, then a short tail
		while (n_taken != n_posted) begin
			@(posedge clk);
		end
		while (encoded_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (n_errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ----- multipart_field_to_url_encoding.f -----
hw/rtl/mf2u_pkg.sv
hw/rtl/mf2u_front.sv
hw/rtl/mf2u_queue.sv
hw/rtl/mf2u_back.sv
hw/rtl/multipart_field_to_url_encoding.sv
bench/testbench.sv
